// ===== sv/efg_pkg.sv =====
package efg_pkg;

  localparam int unsigned NumFlagsDef   = 16;
  localparam int unsigned NumWaitersDef = 8;
  localparam int unsigned MaskW         = 16;
  localparam int unsigned WordW         = 32;
  localparam int unsigned TaskW         = 8;

  typedef enum logic [2:0] {
    ACT_SET   = 3'd0,
    ACT_CLEAR = 3'd1,
    ACT_WAIT  = 3'd2,
    ACT_POLL  = 3'd3,
    ACT_QUERY = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOMATCH  = 3'd2,
    ST_BUSY     = 3'd3,
    ST_QUEUED   = 3'd4,
    ST_FULL     = 3'd5,
    ST_RELEASED = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_FINAL,
    S_OUT
  } state_e;

  // result handed from sequencer to output register
  typedef struct packed {
    logic [2:0]       status;
    logic [TaskW-1:0] task_res;
    logic [WordW-1:0] flag_value;
    logic             last;
  } result_t;

  function automatic logic flag_match(input logic [WordW-1:0] word,
                                      input logic [WordW-1:0] pat,
                                      input logic any);
    if (any) return (word & pat) != '0;
    return (word & pat) == pat;
  endfunction

endpackage

// ===== sv/efg_queue.sv =====
// Waiter FIFO: packed slots, append at tail, remove with compaction.
module efg_queue #(
  parameter int unsigned NumFlags   = efg_pkg::NumFlagsDef,
  parameter int unsigned NumWaiters = efg_pkg::NumWaitersDef,
  localparam int unsigned FW = (NumFlags > 1) ? $clog2(NumFlags) : 1,
  localparam int unsigned SW = (NumWaiters > 1) ? $clog2(NumWaiters) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [efg_pkg::TaskW-1:0] push_task_i,
  input  logic [FW-1:0]             push_flag_i,
  input  logic [efg_pkg::WordW-1:0] push_pat_i,
  input  logic [1:0]                push_mode_i,
  input  logic                      pop_i,
  input  logic [SW-1:0]             pop_slot_i,
  input  logic [SW-1:0]             rd_slot_i,
  output logic                      rd_valid_o,
  output logic [efg_pkg::TaskW-1:0] rd_task_o,
  output logic [FW-1:0]             rd_flag_o,
  output logic [efg_pkg::WordW-1:0] rd_pat_o,
  output logic [1:0]                rd_mode_o,
  output logic [SW:0]               count_o
);
  logic [NumWaiters-1:0]           valid_q;
  logic [efg_pkg::TaskW-1:0]       task_q [NumWaiters];
  logic [FW-1:0]                   flag_q [NumWaiters];
  logic [efg_pkg::WordW-1:0]       pat_q  [NumWaiters];
  logic [1:0]                      mode_q [NumWaiters];
  logic [SW:0]                     count_q;

  assign count_o    = count_q;
  assign rd_valid_o = valid_q[rd_slot_i];
  assign rd_task_o  = task_q[rd_slot_i];
  assign rd_flag_o  = flag_q[rd_slot_i];
  assign rd_pat_o   = pat_q[rd_slot_i];
  assign rd_mode_o  = mode_q[rd_slot_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (pop_i) begin
      for (int i = 0; i < NumWaiters; i++) begin
        if (i >= pop_slot_i) valid_q[i] <= (i + 1 < NumWaiters) ? valid_q[i+1] : 1'b0;
      end
      count_q <= count_q - 1'b1;
    end else if (push_i) begin
      valid_q[count_q[SW-1:0]] <= 1'b1;
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      for (int i = 0; i + 1 < NumWaiters; i++) begin
        if (i >= pop_slot_i) begin
          task_q[i] <= task_q[i+1];
          flag_q[i] <= flag_q[i+1];
          pat_q[i]  <= pat_q[i+1];
          mode_q[i] <= mode_q[i+1];
        end
      end
    end else if (push_i) begin
      task_q[count_q[SW-1:0]] <= push_task_i;
      flag_q[count_q[SW-1:0]] <= push_flag_i;
      pat_q[count_q[SW-1:0]]  <= push_pat_i;
      mode_q[count_q[SW-1:0]] <= push_mode_i;
    end
  end
endmodule

// ===== sv/efg_seq.sv =====
// Sequencer: one slot is examined per cycle by a shared match/compare unit, unless output back-pressure holds it.
module efg_seq #(
  parameter int unsigned NumFlags   = efg_pkg::NumFlagsDef,
  parameter int unsigned NumWaiters = efg_pkg::NumWaitersDef,
  localparam int unsigned FW = (NumFlags > 1) ? $clog2(NumFlags) : 1,
  localparam int unsigned SW = (NumWaiters > 1) ? $clog2(NumWaiters) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                action_i,
  input  logic [3:0]                flag_id_i,
  input  logic [efg_pkg::WordW-1:0] pattern_i,
  input  logic                      wait_any_i,
  input  logic                      clear_on_release_i,
  input  logic [efg_pkg::TaskW-1:0] caller_task_i,
  input  logic [efg_pkg::MaskW-1:0] mask_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output efg_pkg::result_t          res_o
);
  efg_pkg::state_e state_q, state_d;
  logic [2:0]                 act_q;
  logic [FW-1:0]              f_q;
  logic [FW-1:0]              f_in;
  logic [efg_pkg::WordW-1:0]  pat_q;
  logic                       any_q, clr_q;
  logic [efg_pkg::TaskW-1:0]  caller_q;
  logic [SW:0]                slot_q, slot_d;
  logic                       rel_q, rel_d;
  logic [efg_pkg::WordW-1:0]  words_q [NumFlags];
  logic [efg_pkg::WordW-1:0]  word;
  logic                       wr_word;
  logic [efg_pkg::WordW-1:0]  wr_val;
  efg_pkg::result_t           res_q, res_d;
  logic                       rv_q, rv_d;

  logic                       q_valid, push, pop;
  logic [efg_pkg::TaskW-1:0]  q_task;
  logic [FW-1:0]              q_flag;
  logic [efg_pkg::WordW-1:0]  q_pat;
  logic [1:0]                 q_mode;
  logic [SW:0]                q_count;
  logic                       in_slot, hit, multi;

  efg_queue #(.NumFlags(NumFlags), .NumWaiters(NumWaiters)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_task_i(caller_q), .push_flag_i(f_q), .push_pat_i(pat_q),
    .push_mode_i({clr_q, any_q}),
    .pop_i(pop), .pop_slot_i(slot_q[SW-1:0]), .rd_slot_i(slot_q[SW-1:0]),
    .rd_valid_o(q_valid), .rd_task_o(q_task), .rd_flag_o(q_flag), .rd_pat_o(q_pat),
    .rd_mode_o(q_mode), .count_o(q_count)
  );

  assign word    = words_q[f_q];
  assign in_slot = (slot_q < (SW+1)'(NumWaiters)) && q_valid && (q_flag == f_q);
  assign hit     = in_slot && efg_pkg::flag_match(word, q_pat, q_mode[0]);
  assign multi   = (32'(f_q) < efg_pkg::MaskW) ? mask_i[f_q] : 1'b0;
  assign in_ready_o  = (state_q == efg_pkg::S_IDLE);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  // flag id folded into range; the modulo is between loop constants only
  always_comb begin
    f_in = '0;
    for (int k = 0; k < 16; k++) begin
      if (flag_id_i == 4'(k)) f_in = FW'(k % NumFlags);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= efg_pkg::S_IDLE;
      rv_q    <= 1'b0;
      for (int i = 0; i < NumFlags; i++) words_q[i] <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
      if (wr_word) words_q[f_q] <= wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q    <= action_i;
      f_q      <= f_in;
      pat_q    <= pattern_i;
      any_q    <= wait_any_i;
      clr_q    <= clear_on_release_i;
      caller_q <= caller_task_i;
    end
    slot_q    <= slot_d;
    rel_q     <= rel_d;
    res_q     <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    rel_d     = rel_q;
    res_d     = res_q;
    rv_d      = rv_q;
    wr_word   = 1'b0;
    wr_val    = word;
    push      = 1'b0;
    pop       = 1'b0;
    if (rv_q && res_ready_i) rv_d = 1'b0;
    unique case (state_q)
      efg_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d   = efg_pkg::S_SCAN;
          slot_d    = '0;
          rel_d     = 1'b0;
        end
      end
      efg_pkg::S_SCAN: begin
        res_d.last = 1'b1;
        res_d.task_res = caller_q;
        res_d.flag_value = '0;
        state_d = efg_pkg::S_OUT;
        unique case (act_q)
          efg_pkg::ACT_SET: begin
            if (pat_q == '0) begin
              res_d.status = efg_pkg::ST_OK; res_d.task_res = '0; res_d.flag_value = word;
            end else begin
              if (!rel_q) begin
                wr_word = 1'b1; wr_val = word | pat_q; rel_d = 1'b1;
                state_d = efg_pkg::S_SCAN;
              end else if (hit) begin
                state_d = efg_pkg::S_EMIT;
              end else if (slot_q < (SW+1)'(NumWaiters) && q_valid) begin
                slot_d = slot_q + 1'b1;
                state_d = efg_pkg::S_SCAN;
              end else begin
                state_d = efg_pkg::S_FINAL;
              end
            end
          end
          efg_pkg::ACT_CLEAR: begin
            wr_word = 1'b1; wr_val = word & pat_q;
            res_d.status = efg_pkg::ST_OK; res_d.task_res = '0;
            res_d.flag_value = word & pat_q;
          end
          efg_pkg::ACT_WAIT, efg_pkg::ACT_POLL: begin
            if (pat_q == '0) begin
              res_d.status = efg_pkg::ST_ZERO;
            end else if (efg_pkg::flag_match(word, pat_q, any_q)) begin
              res_d.status = efg_pkg::ST_OK; res_d.flag_value = word;
              if (clr_q) begin wr_word = 1'b1; wr_val = '0; end
            end else if (act_q == efg_pkg::ACT_POLL) begin
              res_d.status = efg_pkg::ST_NOMATCH;
            end else if (in_slot && !multi) begin
              res_d.status = efg_pkg::ST_BUSY;
            end else if (slot_q < (SW+1)'(NumWaiters) && q_valid) begin
              slot_d = slot_q + 1'b1;
              state_d = efg_pkg::S_SCAN;
            end else if (q_count >= (SW+1)'(NumWaiters)) begin
              res_d.status = efg_pkg::ST_FULL;
            end else begin
              push = 1'b1;
              res_d.status = efg_pkg::ST_QUEUED;
            end
          end
          efg_pkg::ACT_QUERY: begin
            if (in_slot) begin
              res_d.status = efg_pkg::ST_OK; res_d.task_res = q_task; res_d.flag_value = word;
            end else if (slot_q < (SW+1)'(NumWaiters) && q_valid) begin
              slot_d = slot_q + 1'b1;
              state_d = efg_pkg::S_SCAN;
            end else begin
              res_d.status = efg_pkg::ST_OK; res_d.task_res = '0; res_d.flag_value = word;
            end
          end
          default: begin
            res_d.status = efg_pkg::ST_OK; res_d.task_res = '0;
          end
        endcase
        if (state_d == efg_pkg::S_OUT) begin
          rv_d = 1'b1;
          state_d = efg_pkg::S_IDLE;
        end else begin
          // still scanning: a result waiting in the output register stays put
          res_d = res_q;
        end
      end
      efg_pkg::S_EMIT: begin
        // releases the matched waiter once the output slot is free
        if (!rv_q || res_ready_i) begin
          res_d.status = efg_pkg::ST_RELEASED;
          res_d.task_res = q_task;
          res_d.flag_value = word;
          res_d.last = 1'b0;
          rv_d = 1'b1;
          if (q_mode[1]) begin wr_word = 1'b1; wr_val = '0; end
          pop = 1'b1;
          state_d = efg_pkg::S_SCAN;
        end
      end
      efg_pkg::S_FINAL: begin
        if (!rv_q || res_ready_i) begin
          res_d.status = efg_pkg::ST_OK;
          res_d.task_res = '0;
          res_d.flag_value = word;
          res_d.last = 1'b1;
          rv_d = 1'b1;
          state_d = efg_pkg::S_IDLE;
        end
      end
      default: state_d = efg_pkg::S_IDLE;
    endcase
    // results decided in scan (zero-pattern sets too) leave scan only when output register is free
    if (state_q == efg_pkg::S_SCAN && state_d == efg_pkg::S_IDLE && rv_q && !res_ready_i) begin
      state_d = efg_pkg::S_SCAN; rv_d = rv_q; res_d = res_q; slot_d = slot_q;
      wr_word = 1'b0; push = 1'b0;
    end
  end
endmodule

// ===== sv/event_flag_group_unit.sv =====
// Event-flag group engine.
// Requests arrive on s_axis (action, flag id, pattern, mode bits, caller);
// results leave on m_axis, one or more per request, tlast on the final one.
// User must write multi_waiter_mask via cfg_valid_i/cfg_ready_o only while idle; block does not enforce it.
// One queue slot is examined per cycle by the shared match unit, unless m_axis stalls it.
// A clear, a poll, a zero-pattern set or an immediate match is answered
// without a queue scan; a query scans past waiters on other flags and a
// blocking wait scans the queued waiters. A set with a non-zero pattern
// first updates the flag word, then scans the queue and releases each
// matching waiter, then sends a final result.
// s_axis_tready is high only while no request is in progress.
// Results sit in a single output register; while the receiver stalls the
// sequencer holds before writing the next result, state unchanged.
// Reset clears all flag words, the waiter queue and the mask register.
module event_flag_group_unit #(
  parameter int unsigned NUM_FLAGS   = efg_pkg::NumFlagsDef,
  parameter int unsigned NUM_WAITERS = efg_pkg::NumWaitersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[2:0], flag_id[6:3], pattern[38:7], wait_any[39], clear_on_release[40],
  // caller_task[48:41]
  input  logic [55:0] s_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], task_res[10:3], flag_value[42:11]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  logic [efg_pkg::MaskW-1:0] mask_q;
  efg_pkg::result_t res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mask_q <= '0;
    else if (cfg_valid_i) mask_q <= cfg_data_i;
  end

  efg_seq #(.NumFlags(NUM_FLAGS), .NumWaiters(NUM_WAITERS)) u_seq (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .action_i(s_axis_tdata[2:0]), .flag_id_i(s_axis_tdata[6:3]),
    .pattern_i(s_axis_tdata[38:7]), .wait_any_i(s_axis_tdata[39]),
    .clear_on_release_i(s_axis_tdata[40]), .caller_task_i(s_axis_tdata[48:41]),
    .mask_i(mask_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {5'd0, res.flag_value, res.task_res, res.status};
  assign m_axis_tlast = res.last;
endmodule

// ===== verif/tb_event_flag_group_unit.sv =====
`timescale 1ns / 1ps

module tb_event_flag_group_unit;

  localparam int NFLAG = 16;
  localparam int NWAIT = 8;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  act;
    logic [3:0]  flag;
    logic [31:0] pat;
    logic        any;
    logic        clr;
    logic [7:0]  caller;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  task_id;
    logic [31:0] value;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [3:0]  flag;
    logic [31:0] pat;
    logic        any;
    logic        clr;
  } waiter_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic m_axis_tlast;

  // predictor state
  logic [31:0] words [NFLAG];
  waiter_t     fifo_q [$];
  logic [15:0] multi_mask = '0;

  req_t pending_q [$];
  res_t expected_q [$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   hold_rx = 1'b0;
  int   hold_len = 0;
  bit   stim_done = 1'b0;

  always #10 clk_i = ~clk_i;

  event_flag_group_unit DUT (.*);

  function automatic bit pattern_hit(logic [31:0] w, logic [31:0] p, logic any);
    return any ? ((w & p) != 0) : ((w & p) == p);
  endfunction

  function automatic res_t mk(logic [2:0] st, logic [7:0] t, logic [31:0] v, logic l);
    res_t r;
    r.status = st; r.task_id = t; r.value = v; r.last = l;
    return r;
  endfunction

  // computes the results of one request and advances the flag/waiter state
  task automatic predict_request(req_t rq);
    int s;
    bit blocked;
    logic [31:0] w;
    logic [7:0] head;
    s = 0;
    blocked = 0;
    head = '0;
    case (rq.act)
      efg_pkg::ACT_SET: begin
        if (rq.pat != 0) begin
          words[rq.flag] |= rq.pat;
          while (s < fifo_q.size()) begin
            if (fifo_q[s].flag == rq.flag &&
                pattern_hit(words[rq.flag], fifo_q[s].pat, fifo_q[s].any)) begin
              expected_q.push_back(mk(efg_pkg::ST_RELEASED, fifo_q[s].task_id,
                                      words[rq.flag], 0));
              if (fifo_q[s].clr) words[rq.flag] = '0;
              fifo_q.delete(s);
            end else s++;
          end
        end
        expected_q.push_back(mk(efg_pkg::ST_OK, 0, words[rq.flag], 1));
      end
      efg_pkg::ACT_CLEAR: begin
        words[rq.flag] &= rq.pat;
        expected_q.push_back(mk(efg_pkg::ST_OK, 0, words[rq.flag], 1));
      end
      efg_pkg::ACT_WAIT, efg_pkg::ACT_POLL: begin
        w = words[rq.flag];
        if (rq.pat == 0) expected_q.push_back(mk(efg_pkg::ST_ZERO, rq.caller, 0, 1));
        else if (pattern_hit(w, rq.pat, rq.any)) begin
          expected_q.push_back(mk(efg_pkg::ST_OK, rq.caller, w, 1));
          if (rq.clr) words[rq.flag] = '0;
        end else if (rq.act == efg_pkg::ACT_POLL)
          expected_q.push_back(mk(efg_pkg::ST_NOMATCH, rq.caller, 0, 1));
        else begin
          foreach (fifo_q[i])
            if (fifo_q[i].flag == rq.flag && !multi_mask[rq.flag]) blocked = 1;
          if (blocked) expected_q.push_back(mk(efg_pkg::ST_BUSY, rq.caller, 0, 1));
          else if (fifo_q.size() >= NWAIT)
            expected_q.push_back(mk(efg_pkg::ST_FULL, rq.caller, 0, 1));
          else begin
            fifo_q.push_back('{rq.caller, rq.flag, rq.pat, rq.any, rq.clr});
            expected_q.push_back(mk(efg_pkg::ST_QUEUED, rq.caller, 0, 1));
          end
        end
      end
      efg_pkg::ACT_QUERY: begin
        for (int i = fifo_q.size() - 1; i >= 0; i--)
          if (fifo_q[i].flag == rq.flag) head = fifo_q[i].task_id;
        expected_q.push_back(mk(efg_pkg::ST_OK, head, words[rq.flag], 1));
      end
      default: expected_q.push_back(mk(efg_pkg::ST_OK, 0, 0, 1));
    endcase
  endtask

  function automatic req_t mk_req(logic [2:0] a, logic [3:0] f, logic [31:0] p,
                                  logic any, logic clr, logic [7:0] c);
    req_t r;
    r.act = a; r.flag = f; r.pat = p; r.any = any; r.clr = clr; r.caller = c;
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 6) ? 0 :
           ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_pat();
    case ($urandom_range(0, 4))
      0: return 32'd1 << $urandom_range(0, 31);
      1: return $urandom_range(0, 15) << ($urandom_range(0, 7) * 4);
      2: return '0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // driver
  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_request(pending_q.pop_front());
      tx_gap = gap_len();
    end
    if (rst_ni && pending_q.size() > 0 && (s_axis_tvalid && !s_axis_tready)) begin
      // keep offering the same request
    end else if (rst_ni && pending_q.size() > 0 && tx_gap == 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {7'd0, pending_q[0].caller, pending_q[0].clr, pending_q[0].any,
                        pending_q[0].pat, pending_q[0].flag, pending_q[0].act};
    end else begin
      s_axis_tvalid <= 1'b0;
      if (tx_gap > 0) tx_gap--;
    end
  end

  // monitor and receiver back-pressure
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got = mk(m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[42:11], m_axis_tlast);
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected st=%0d task=%0d val=%h last=%b, actual st=%0d task=%0d val=%h last=%b",
                   $time, exp_r.status, exp_r.task_id, exp_r.value, exp_r.last,
                   got.status, got.task_id, got.value, got.last);
          errors++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (hold_len > 0) begin
      hold_len--;
      m_axis_tready <= 1'b0;
    end else if (hold_rx) begin
      hold_len = 300;
      hold_rx = 1'b0;
      m_axis_tready <= 1'b0;
    end else if (stim_done)
      m_axis_tready <= 1'b1;
    else
      m_axis_tready <= ($urandom_range(0, 9) < 7) ? 1'b1 :
                       ($urandom_range(0, 9) < 9) ? 1'b0 : 1'b0;
    if (!stim_done && $urandom_range(0, 199) == 0 && hold_len == 0) hold_len = $urandom_range(10, 40);
  end

  always @(posedge clk_i)
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("event_flag_group_unit verification failed");
      $finish;
    end

  task automatic drain();
    wait (pending_q.size() == 0 && !s_axis_tvalid);
    wait (expected_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_mask(logic [15:0] m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    multi_mask = m;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int f;
    for (int i = 0; i < n; i++) begin
      f = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 8) begin
        // well-formed: waits, sets, clears, polls and queries on flags 0 to 3
        case ($urandom_range(0, 5))
          0, 1: pending_q.push_back(mk_req(efg_pkg::ACT_WAIT, f, rand_pat(), $urandom,
                                           $urandom, $urandom_range(1, 255)));
          2: pending_q.push_back(mk_req(efg_pkg::ACT_SET, f, rand_pat(), $urandom, $urandom,
                                        $urandom));
          3: pending_q.push_back(mk_req(efg_pkg::ACT_CLEAR, f, $urandom, $urandom, $urandom,
                                        $urandom));
          4: pending_q.push_back(mk_req(efg_pkg::ACT_POLL, f, rand_pat(), $urandom, $urandom,
                                        $urandom_range(0, 255)));
          default: pending_q.push_back(mk_req(efg_pkg::ACT_QUERY, f, $urandom, $urandom,
                                              $urandom, $urandom));
        endcase
      end else
        pending_q.push_back(mk_req($urandom_range(0, 7), $urandom, $urandom, $urandom,
                                   $urandom, $urandom));
    end
  endtask

  initial begin
    foreach (words[i]) words[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: default single-waiter mask
    pending_q.push_back(mk_req(efg_pkg::ACT_QUERY, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_req(efg_pkg::ACT_WAIT, 1, 0, 0, 0, 9));
    pending_q.push_back(mk_req(efg_pkg::ACT_POLL, 1, 32'h1, 1, 0, 9));
    pending_q.push_back(mk_req(efg_pkg::ACT_WAIT, 1, 32'hF0, 0, 1, 8'hFF));
    pending_q.push_back(mk_req(efg_pkg::ACT_WAIT, 1, 32'h1, 1, 0, 0));
    pending_q.push_back(mk_req(efg_pkg::ACT_QUERY, 1, 0, 0, 0, 0));
    pending_q.push_back(mk_req(efg_pkg::ACT_SET, 1, 0, 0, 0, 0));
    pending_q.push_back(mk_req(efg_pkg::ACT_SET, 1, 32'h30, 0, 0, 0));
    pending_q.push_back(mk_req(efg_pkg::ACT_SET, 1, 32'hC0, 0, 0, 0));
    pending_q.push_back(mk_req(efg_pkg::ACT_SET, 15, 32'hFFFF_FFFF, 0, 0, 0));
    pending_q.push_back(mk_req(efg_pkg::ACT_WAIT, 15, 32'h8000_0000, 0, 1, 3));
    pending_q.push_back(mk_req(efg_pkg::ACT_CLEAR, 15, 32'h0000_FFFF, 0, 0, 0));
    pending_q.push_back(mk_req(efg_pkg::ACT_POLL, 15, 32'h1_0000, 1, 0, 4));
    pending_q.push_back(mk_req(3'd5, 2, 32'hFFFF_FFFF, 1, 1, 8'hFF));
    pending_q.push_back(mk_req(3'd7, 2, 0, 0, 0, 0));
    for (int i = 0; i < NWAIT; i++)
      pending_q.push_back(mk_req(efg_pkg::ACT_WAIT, i, 32'h100, 0, 0, 8'(10 + i)));
    pending_q.push_back(mk_req(efg_pkg::ACT_WAIT, 9, 32'h100, 0, 0, 77));
    drain();

    write_mask(16'hFFFF);
    // empty the queue, then eight waiters on one flag and one set releases them all
    for (int i = 0; i < NWAIT; i++)
      pending_q.push_back(mk_req(efg_pkg::ACT_SET, i, 32'h100, 0, 0, 0));
    for (int i = 0; i < NWAIT; i++)
      pending_q.push_back(mk_req(efg_pkg::ACT_WAIT, 5, 32'h200, i[0], 0, 8'(20 + i)));
    pending_q.push_back(mk_req(efg_pkg::ACT_WAIT, 5, 32'h200, 0, 0, 99));
    pending_q.push_back(mk_req(efg_pkg::ACT_SET, 5, 32'h200, 0, 0, 0));
    hold_rx = 1'b1;
    drain();

    write_mask(16'hA5A5);
    random_phase(100);
    drain();
    write_mask(16'h0000);
    random_phase(100);
    // sender pause until all results are back
    drain();
    write_mask($urandom_range(0, 65535));
    random_phase(60);
    hold_rx = 1'b1;
    random_phase(60);
    stim_done = 1'b1;
    drain();

    if (errors == 0)
      $display("event_flag_group_unit verification clean");
    else
      $display("event_flag_group_unit verification failed");
    $finish;
  end

endmodule
